@@ rtl/wto_pkg.sv @@
`default_nettype none
package wto_pkg;

	// fixed field widths
	localparam int TIME_BITS   = 32;
	localparam int INDEX_BITS  = 10;
	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 16;
	localparam int OPC_BITS    = 2;

	// input opcodes
	localparam logic [OPC_BITS-1:0] OPC_WRITE   = 2'd0;
	localparam logic [OPC_BITS-1:0] OPC_TRIGGER = 2'd1;
	localparam logic [OPC_BITS-1:0] OPC_EVAL    = 2'd2;
	localparam logic [OPC_BITS-1:0] OPC_UNUSED  = 2'd3;

	// kind of work handed to the back end
	typedef enum logic {
		KIND_WRITE,
		KIND_EVAL
	} kind_t;

	// queued item: arg holds the elapsed time for an evaluation
	typedef struct packed {
		kind_t                   kind;
		logic [TIME_BITS-1:0]    arg;
		logic [INDEX_BITS-1:0]   index;
		logic [SAMPLE_BITS-1:0]  value;
	} qitem_t;

	// back end sequencer states
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_POS,
		BK_RDA,
		BK_RDB,
		BK_MIX
	} back_state_t;

endpackage
`default_nettype wire

@@ rtl/wto_front.sv @@
`default_nettype none
module wto_front (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire  [wto_pkg::OPC_BITS-1:0]        opcode,
	input  wire  [wto_pkg::TIME_BITS-1:0]       time_value,
	input  wire  [wto_pkg::INDEX_BITS-1:0]      entry_index,
	input  wire  signed [wto_pkg::SAMPLE_BITS-1:0] entry_value,
	input  wire                                 q_ready,
	output logic                                q_push,
	output wto_pkg::qitem_t                     q_item
);
	import wto_pkg::*;

	logic [TIME_BITS-1:0] trigger_q;
	logic                 accept;

	// take an item whenever the queue has room
	assign in_ready = q_ready;
	assign accept   = in_valid && q_ready;

	// classify: triggers stay here, writes and evaluations go to the queue
	always_comb begin
		q_push      = 1'b0;
		q_item.kind = KIND_WRITE;
		q_item.arg  = time_value - trigger_q;
		q_item.index = entry_index;
		q_item.value = entry_value;
		case (opcode)
			OPC_WRITE: begin
				q_push = accept;
			end
			OPC_EVAL: begin
				q_push      = accept;
				q_item.kind = KIND_EVAL;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	// trigger time register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_q <= '0;
		end else if (accept && opcode == OPC_TRIGGER) begin
			trigger_q <= time_value;
		end
	end

endmodule
`default_nettype wire

@@ rtl/wto_queue.sv @@
`default_nettype none
module wto_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	output logic             push_ready,
	input  wto_pkg::qitem_t  push_item,
	output logic             pop_valid,
	input  wire              pop,
	output wto_pkg::qitem_t  pop_item
);
	import wto_pkg::*;

	qitem_t     entries_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = entries_q[rd_ptr_q];

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push && push_ready) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push && push_ready) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop && pop_valid) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push && push_ready, pop && pop_valid})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/wto_back.sv @@
`default_nettype none
module wto_back #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire  [wto_pkg::TIME_BITS-1:0]          phase_rate,
	input  wire                                    q_valid,
	input  wto_pkg::qitem_t                        q_item,
	output logic                                   q_pop,
	output logic                                   out_valid,
	input  wire                                    out_ready,
	output logic signed [wto_pkg::SAMPLE_BITS-1:0] sample
);
	import wto_pkg::*;

	localparam int AW       = $clog2(TABLE_DEPTH);
	localparam int POS_BITS = TIME_BITS + AW + 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
	localparam logic [POS_BITS-1:0] DEPTH_W = POS_BITS'(TABLE_DEPTH);

	back_state_t state_q, state_d;

	// table memory
	logic [SAMPLE_BITS-1:0] mem [TABLE_DEPTH];
	logic                   mem_we;
	logic [AW-1:0]          mem_wa;
	logic                   mem_re;
	logic [AW-1:0]          mem_ra;
	logic [SAMPLE_BITS-1:0] rd_q;

	// datapath
	logic [TIME_BITS-1:0]         phase_s1;
	logic [AW-1:0]                idx_s2;
	logic [AW-1:0]                nxt_s2;
	logic [FRAC_BITS-1:0]         frac_s2;
	logic signed [SAMPLE_BITS-1:0] prev_s3;
	logic [2*TIME_BITS-1:0]       phase_prod;
	logic [POS_BITS-1:0]          pos;
	logic signed [SAMPLE_BITS:0]  dlt;
	logic signed [SAMPLE_BITS+17:0] prod;
	logic signed [SAMPLE_BITS-1:0] mix;

	logic out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic out_free;
	logic in_range;
	logic load_out;

	assign out_free = !out_valid_q || out_ready;
	assign in_range = ({{(POS_BITS-INDEX_BITS){1'b0}}, q_item.index} < DEPTH_W);

	// phase and table position
	assign phase_prod = q_item.arg * phase_rate;
	assign pos        = {{(AW+1){1'b0}}, phase_s1} * DEPTH_W;

	// interpolation: prev + floor((next - prev) * frac / 2^16)
	assign dlt  = $signed({rd_q[SAMPLE_BITS-1], rd_q}) -
	              $signed({prev_s3[SAMPLE_BITS-1], prev_s3});
	assign prod = dlt * $signed({1'b0, frac_s2});
	assign mix  = prev_s3 + $signed(prod[FRAC_BITS +: SAMPLE_BITS]);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid && q_item.kind == KIND_EVAL) begin
					state_d = BK_POS;
				end
			end
			BK_POS:  state_d = BK_RDA;
			BK_RDA:  state_d = BK_RDB;
			BK_RDB:  state_d = BK_MIX;
			BK_MIX: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		q_pop    = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = AW'(q_item.index);
		mem_re   = 1'b0;
		mem_ra   = idx_s2;
		load_out = 1'b0;
		case (state_q)
			BK_IDLE: begin
				q_pop  = q_valid;
				mem_we = q_valid && q_item.kind == KIND_WRITE && in_range;
			end
			BK_RDA: begin
				mem_re = 1'b1;
			end
			BK_RDB: begin
				mem_re = 1'b1;
				mem_ra = nxt_s2;
			end
			BK_MIX: begin
				load_out = out_free;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	// table memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= q_item.value;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE) begin
			phase_s1 <= phase_prod[TIME_BITS-1:0];
		end
		if (state_q == BK_POS) begin
			idx_s2  <= pos[TIME_BITS +: AW];
			frac_s2 <= pos[FRAC_BITS +: FRAC_BITS];
			nxt_s2  <= (pos[TIME_BITS +: AW] == LAST_IDX) ? '0 : pos[TIME_BITS +: AW] + 1'b1;
		end
		if (state_q == BK_RDB) begin
			prev_s3 <= rd_q;
		end
		if (load_out) begin
			sample_q <= mix;
		end
	end

	// sequencer state and output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;

endmodule
`default_nettype wire

@@ rtl/wavetable_oscillator_interp.sv @@
`default_nettype none
// Wavetable oscillator with linear interpolation. Opcode 0 writes one table
// entry (ignored when entry_index is not below TABLE_DEPTH), opcode 1 records
// a trigger time, opcode 2 returns one sample interpolated at
// phase = (time_value - trigger) * phase_rate mod 2^32; opcode 3 does nothing.
// The front end takes one item per cycle while its two-entry queue has room;
// triggers finish there. The back end writes the table in its idle state and
// evaluates in steps: dequeue with the 32x32 phase multiply, table position,
// two reads through the single table read port, interpolation. A finished
// sample waits in the output register; the next item goes ahead, and only a
// following evaluation holds in its mix step until that register is free.
// Table entries hold no reset value: evaluate only after every entry the
// phase can reach has been written. phase_rate is written through the cfg
// channel, always ready; the user must do so only while idle (not enforced).
module wavetable_oscillator_interp #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    in_valid,
	output logic                                   in_ready,
	input  wire  [wto_pkg::OPC_BITS-1:0]           opcode,
	input  wire  [wto_pkg::TIME_BITS-1:0]          time_value,
	input  wire  [wto_pkg::INDEX_BITS-1:0]         entry_index,
	input  wire  signed [wto_pkg::SAMPLE_BITS-1:0] entry_value,
	output logic                                   out_valid,
	input  wire                                    out_ready,
	output logic signed [wto_pkg::SAMPLE_BITS-1:0] sample,
	input  wire                                    cfg_valid,
	output logic                                   cfg_ready,
	input  wire  [wto_pkg::TIME_BITS-1:0]          cfg_data
);
	import wto_pkg::*;

	logic [TIME_BITS-1:0] phase_rate_q;
	logic   q_push;
	logic   q_ready;
	qitem_t q_in;
	logic   q_valid;
	logic   q_pop;
	qitem_t q_out;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_rate_q <= '0;
		end else if (cfg_valid) begin
			phase_rate_q <= cfg_data;
		end
	end

	// accept and classify
	wto_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.time_value  (time_value),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.q_ready     (q_ready),
		.q_push      (q_push),
		.q_item      (q_in)
	);

	// decoupling queue
	wto_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_ready (q_ready),
		.push_item  (q_in),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_item   (q_out)
	);

	// table and interpolation
	wto_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.phase_rate (phase_rate_q),
		.q_valid    (q_valid),
		.q_item     (q_out),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample     (sample)
	);

	// checks
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> q_ready)
		else $error("queue push without room");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue pop while empty");

	a_trig_local: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (opcode == OPC_TRIGGER || opcode == OPC_UNUSED)) |-> !q_push)
		else $error("trigger or unused opcode reached the queue");

endmodule
`default_nettype wire
